// ===== src/cssk_pkg.sv =====
`timescale 1ns / 1ps
// shared types, class and script codes, and the letter folding tables for the sort key unit
// no dependencies

package cssk_pkg;

    // script ids
    localparam logic [6:0] SCR_LATIN    = 7'd0;
    localparam logic [6:0] SCR_GREEK    = 7'd1;
    localparam logic [6:0] SCR_CYRIL    = 7'd2;
    localparam logic [6:0] SCR_HEBREW   = 7'd3;
    localparam logic [6:0] SCR_ARABIC   = 7'd4;
    localparam logic [6:0] SCR_DEVA     = 7'd5;
    localparam logic [6:0] SCR_CJK      = 7'd6;
    localparam logic [6:0] SCR_EMOTICON = 7'd7;
    localparam logic [6:0] SCR_PICTO    = 7'd8;
    localparam logic [6:0] SCR_OTHER    = 7'd100;

    // semantic classes
    localparam logic [7:0] CLS_LATIN    = 8'd1;
    localparam logic [7:0] CLS_DIGIT    = 8'd3;
    localparam logic [7:0] CLS_GREEK    = 8'd4;
    localparam logic [7:0] CLS_CYRIL    = 8'd5;
    localparam logic [7:0] CLS_PUNCT    = 8'd10;
    localparam logic [7:0] CLS_EMOTICON = 8'd20;
    localparam logic [7:0] CLS_PICTO    = 8'd21;
    localparam logic [7:0] CLS_CJK      = 8'd30;
    localparam logic [7:0] CLS_SURR     = 8'd50;
    localparam logic [7:0] CLS_OTHER    = 8'd99;

    // case variants (high nibble of the variant byte)
    localparam logic [1:0] VAR_UPPER  = 2'd0;
    localparam logic [1:0] VAR_LOWER  = 2'd1;
    localparam logic [1:0] VAR_ACCENT = 2'd2;
    localparam logic [1:0] VAR_NONE   = 2'd3;

    // similarity offsets per class
    localparam logic [19:0] SIM_PUNCT_BASE = 20'd100000;
    localparam logic [19:0] SIM_GREEK_BASE = 20'd200000;
    localparam logic [19:0] SIM_CYRIL_BASE = 20'd299000;  // 300000 minus 1000 for base mod 1000
    localparam logic [19:0] SIM_EMO_BASE   = 20'd400000;
    localparam logic [19:0] SIM_PIC_BASE   = 20'd500000;
    localparam logic [19:0] SIM_CJK_BASE   = 20'd600000;
    localparam logic [19:0] SIM_SURR_BASE  = 20'd700000;
    localparam logic [19:0] SIM_OTHER_BASE = 20'd800000;
    localparam logic [19:0] SIM_OTHER_TOP  = 20'd899999;

    // remainder by 100000: q estimate = (cp * RECIP) >> RECIP_SHIFT, low by at most one
    localparam logic [11:0] RECIP       = 12'd2684;
    localparam int          RECIP_SHIFT = 28;
    localparam logic [20:0] MOD_DIV     = 21'd100000;
    localparam logic [20:0] GRP_SCALE   = 21'd1000;

    // stage 1 to stage 2
    typedef struct packed {
        logic [20:0] cp;
        logic [6:0]  script;
        logic [7:0]  cls;
        logic [7:0]  variant;
        logic [10:0] mul;
        logic [19:0] add;
        logic        is_mod;
        logic [32:0] prod;
    } t_s1;

    // stage 2 to stage 3
    typedef struct packed {
        logic [20:0] cp;
        logic [6:0]  script;
        logic [7:0]  cls;
        logic [7:0]  variant;
        logic [20:0] mk;
        logic [19:0] add;
        logic        is_mod;
        logic [20:0] qm;
    } t_s2;

    // accented latin-1 to ascii base, upper greek and cyrillic to lower
    function automatic logic [10:0] f_to_base(input logic [10:0] c);
        logic [10:0] b;
        b = c;
        if (c <= 11'h07F) begin
            b = c;
        end else if (c inside {[11'h0C0:11'h0C5]}) begin
            b = 11'h041;
        end else if (c inside {[11'h0C8:11'h0CB]}) begin
            b = 11'h045;
        end else if (c inside {[11'h0CC:11'h0CF]}) begin
            b = 11'h049;
        end else if (c inside {[11'h0D2:11'h0D6]}) begin
            b = 11'h04F;
        end else if (c inside {[11'h0D9:11'h0DC]}) begin
            b = 11'h055;
        end else if (c inside {[11'h0E0:11'h0E5]}) begin
            b = 11'h061;
        end else if (c inside {[11'h0E8:11'h0EB]}) begin
            b = 11'h065;
        end else if (c inside {[11'h0EC:11'h0EF]}) begin
            b = 11'h069;
        end else if (c inside {[11'h0F2:11'h0F6]}) begin
            b = 11'h06F;
        end else if (c inside {[11'h0F9:11'h0FC]}) begin
            b = 11'h075;
        end else if (c inside {[11'h391:11'h3A9], [11'h410:11'h42F]}) begin
            b = c + 11'h020;
        end
        return b;
    endfunction

    // ascii upper to lower
    function automatic logic [10:0] f_fold(input logic [10:0] c);
        logic [10:0] f;
        f = c;
        if (c inside {[11'h041:11'h05A]}) begin
            f = c + 11'h020;
        end
        return f;
    endfunction

    // homoglyph group; unlisted characters are their own group
    function automatic logic [10:0] f_group(input logic [10:0] c);
        logic [10:0] g;
        case (c)
            11'h030, 11'h04F, 11'h06F, 11'h0D8, 11'h0F8: g = 11'd0;
            11'h031, 11'h049, 11'h069, 11'h06C, 11'h07C: g = 11'd1;
            11'h032, 11'h05A, 11'h07A:                   g = 11'd2;
            11'h033:                                     g = 11'd3;
            11'h034:                                     g = 11'd4;
            11'h035, 11'h053, 11'h073:                   g = 11'd5;
            11'h036, 11'h047, 11'h067:                   g = 11'd6;
            11'h037:                                     g = 11'd7;
            11'h038, 11'h042, 11'h062:                   g = 11'd8;
            11'h039, 11'h071:                            g = 11'd9;
            default:                                     g = c;
        endcase
        return g;
    endfunction

endpackage

// ===== src/codepoint_semantic_sort_key_unit.sv =====
`timescale 1ns / 1ps
// top level of the codepoint sort key unit: three register stages with valid/stall flow
// depends on cssk_pkg, cssk_decode, cssk_scale, cssk_pack
//
// Usage
//   Input channel: i_valid / o_stall with i_code_point (21-bit codepoint).
//   Output channel: o_valid / i_stall with o_sort_key (63-bit key).
//   An item moves at a rising edge where valid is high and stall is low.
//   An accepted item passes r_s1 and r_s2, then shows on o_sort_key from r_key.
//   Throughput: one item per cycle while not stalled. Stage 1 decodes the codepoint and forms a
//   reciprocal product, stage 2 does the constant multiplies, stage 3 sums,
//   corrects the remainder by 100000 and packs the key into the output register.
//   When the receiver stalls, the output register holds its item; earlier
//   stages keep filling empty slots, so up to three items are buffered before
//   o_stall rises. Nothing is dropped or repeated.
//   Reset (synchronous, active low) empties all stages; no other state exists.
//   The block has no configuration registers.

module codepoint_semantic_sort_key_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [20:0] i_code_point,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [62:0] o_sort_key
);
    import cssk_pkg::*;

    t_s1         n_s1;
    t_s1         r_s1;
    t_s2         n_s2;
    t_s2         r_s2;
    logic [62:0] n_key;
    logic [62:0] r_key;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        w_en1;
    logic        w_en2;
    logic        w_en3;

    // stage logic
    cssk_decode u_decode (
        .i_cp (i_code_point),
        .o_s1 (n_s1)
    );

    cssk_scale u_scale (
        .i_s1 (r_s1),
        .o_s2 (n_s2)
    );

    cssk_pack u_pack (
        .i_s2  (r_s2),
        .o_key (n_key)
    );

    // a stage loads when it is empty or its item moves on
    assign w_en3   = !r_v3 || !i_stall;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_key <= n_key;
        end
    end

    assign o_valid    = r_v3;
    assign o_sort_key = r_key;

    // a blocked middle item keeps its place and payload
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_en3) |=> (r_v2 && $stable(r_s2)))
        else $error("stage 2 item lost while blocked");

    // unlisted codepoints land in the remainder band
    a_other_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (o_sort_key[55:48] == CLS_OTHER)) |->
        ((o_sort_key[47:28] >= SIM_OTHER_BASE) && (o_sort_key[47:28] <= SIM_OTHER_TOP)))
        else $error("remainder out of range for unlisted codepoint");

    // latin script only for codepoints up to 0x24F
    a_latin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (o_sort_key[62:56] == SCR_LATIN)) |-> (o_sort_key[19:0] <= 20'h0024F))
        else $error("latin script on a codepoint above 0x24F");

    // an item entering a full pipe with a stalled output cannot be accepted
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && i_stall) |-> o_stall)
        else $error("input accepted while all stages are blocked");

endmodule

// ===== src/cssk_decode.sv =====
`timescale 1ns / 1ps
// stage 1: classify one codepoint into script, class, variant and similarity operands
// depends on cssk_pkg

module cssk_decode (
    input  logic [20:0]   i_cp,
    output cssk_pkg::t_s1 o_s1
);
    import cssk_pkg::*;

    logic [10:0] w_base;
    logic [10:0] w_grp;
    logic [20:0] w_d_emo;
    logic [20:0] w_d_pic;
    logic [20:0] w_d_cjk;
    logic [3:0]  w_digit;
    logic        w_up;
    logic        w_lo;
    logic        w_acc;
    logic        w_comb;
    logic [1:0]  w_var;

    // base letter and glyph group, only looked at for codepoints below 0x800
    assign w_base  = f_to_base(i_cp[10:0]);
    assign w_grp   = f_group(f_fold(w_base));
    assign w_d_emo = i_cp - 21'h1F600;
    assign w_d_pic = i_cp - 21'h1F300;
    assign w_d_cjk = i_cp - 21'h04E00;
    assign w_digit = i_cp[3:0];

    // case variant and combining mark flag
    always_comb begin
        w_up   = (i_cp inside {[21'h41:21'h5A], [21'h391:21'h3A9], [21'h410:21'h42F]});
        w_lo   = (i_cp inside {[21'h61:21'h7A], [21'h3B1:21'h3C9], [21'h430:21'h44F]});
        w_acc  = (i_cp inside {[21'h0C0:21'h24F]});
        w_comb = (i_cp inside {[21'h300:21'h36F]});
        if (w_up) begin
            w_var = VAR_UPPER;
        end else if (w_lo) begin
            w_var = VAR_LOWER;
        end else if (w_acc) begin
            w_var = VAR_ACCENT;
        end else begin
            w_var = VAR_NONE;
        end
    end

    // script id
    always_comb begin
        if (i_cp <= 21'h24F) begin
            o_s1.script = SCR_LATIN;
        end else if (i_cp inside {[21'h370:21'h3FF]}) begin
            o_s1.script = SCR_GREEK;
        end else if (i_cp inside {[21'h400:21'h4FF]}) begin
            o_s1.script = SCR_CYRIL;
        end else if (i_cp inside {[21'h590:21'h5FF]}) begin
            o_s1.script = SCR_HEBREW;
        end else if (i_cp inside {[21'h600:21'h77F]}) begin
            o_s1.script = SCR_ARABIC;
        end else if (i_cp inside {[21'h900:21'h97F]}) begin
            o_s1.script = SCR_DEVA;
        end else if (i_cp inside {[21'h2E80:21'h9FFF]}) begin
            o_s1.script = SCR_CJK;
        end else if (i_cp inside {[21'h1F600:21'h1F64F]}) begin
            o_s1.script = SCR_EMOTICON;
        end else if (i_cp inside {[21'h1F300:21'h1F5FF]}) begin
            o_s1.script = SCR_PICTO;
        end else begin
            o_s1.script = SCR_OTHER;
        end
    end

    // class and similarity operands: sim = mul * 1000 + add, or the remainder path
    always_comb begin
        o_s1.mul    = '0;
        o_s1.add    = '0;
        o_s1.is_mod = 1'b0;
        if (i_cp inside {[21'h41:21'h5A], [21'h61:21'h7A], [21'h0C0:21'h24F]}) begin
            o_s1.cls = CLS_LATIN;
            o_s1.mul = w_grp;
            o_s1.add = 20'(w_base);
        end else if (i_cp inside {[21'h30:21'h39]}) begin
            // digit value times ten thousand
            o_s1.cls = CLS_DIGIT;
            o_s1.mul = 11'({w_digit, 3'b000}) + 11'({w_digit, 1'b0});
        end else if (i_cp inside {[21'h21:21'h2F], [21'h3A:21'h40], [21'h5B:21'h60],
                                  [21'h7B:21'h7E]}) begin
            o_s1.cls = CLS_PUNCT;
            o_s1.add = SIM_PUNCT_BASE + 20'(i_cp[6:0]);
        end else if (i_cp inside {[21'h391:21'h3C9]}) begin
            o_s1.cls = CLS_GREEK;
            o_s1.mul = w_base;
            o_s1.add = SIM_GREEK_BASE + 20'(w_base);
        end else if (i_cp inside {[21'h410:21'h44F]}) begin
            o_s1.cls = CLS_CYRIL;
            o_s1.mul = w_base;
            o_s1.add = SIM_CYRIL_BASE + 20'(w_base);
        end else if (i_cp inside {[21'h1F600:21'h1F64F]}) begin
            o_s1.cls = CLS_EMOTICON;
            o_s1.add = SIM_EMO_BASE + 20'(w_d_emo[6:0]);
        end else if (i_cp inside {[21'h1F300:21'h1F5FF]}) begin
            o_s1.cls = CLS_PICTO;
            o_s1.add = SIM_PIC_BASE + 20'(w_d_pic[9:0]);
        end else if (i_cp inside {[21'h4E00:21'h9FFF]}) begin
            o_s1.cls = CLS_CJK;
            o_s1.add = SIM_CJK_BASE + 20'(w_d_cjk[14:0]);
        end else if (i_cp inside {[21'hD800:21'hDFFF]}) begin
            o_s1.cls = CLS_SURR;
            o_s1.add = SIM_SURR_BASE + 20'(i_cp[10:0]);
        end else begin
            o_s1.cls    = CLS_OTHER;
            o_s1.is_mod = 1'b1;
        end
    end

    // remaining fields and the reciprocal product for the remainder
    assign o_s1.cp      = i_cp;
    assign o_s1.variant = {2'b00, w_var, 3'b000, w_comb};
    assign o_s1.prod    = 33'(i_cp) * 33'(RECIP);

endmodule

// ===== src/cssk_scale.sv =====
`timescale 1ns / 1ps
// stage 2: group scaling by 1000 and quotient estimate times 100000
// depends on cssk_pkg

module cssk_scale (
    input  cssk_pkg::t_s1 i_s1,
    output cssk_pkg::t_s2 o_s2
);
    import cssk_pkg::*;

    logic [4:0] w_qe;

    // quotient estimate, never above the true quotient and at most one below
    assign w_qe = i_s1.prod[RECIP_SHIFT+4:RECIP_SHIFT];

    assign o_s2.mk      = 21'(i_s1.mul) * GRP_SCALE;
    assign o_s2.qm      = 21'(w_qe) * MOD_DIV;
    assign o_s2.cp      = i_s1.cp;
    assign o_s2.script  = i_s1.script;
    assign o_s2.cls     = i_s1.cls;
    assign o_s2.variant = i_s1.variant;
    assign o_s2.add     = i_s1.add;
    assign o_s2.is_mod  = i_s1.is_mod;

endmodule

// ===== src/cssk_pack.sv =====
`timescale 1ns / 1ps
// stage 3: remainder correction, similarity sum and key packing
// depends on cssk_pkg

module cssk_pack (
    input  cssk_pkg::t_s2 i_s2,
    output logic [62:0]   o_key
);
    import cssk_pkg::*;

    logic [20:0] w_rem;
    logic [20:0] w_rem_fix;
    logic [21:0] w_sum;
    logic [19:0] w_sim;

    // remainder below twice the divisor, one subtract brings it in range
    assign w_rem     = i_s2.cp - i_s2.qm;
    assign w_rem_fix = (w_rem >= MOD_DIV) ? (w_rem - MOD_DIV) : w_rem;
    assign w_sum     = 22'(i_s2.mk) + 22'(i_s2.add);

    // similarity kept to its low 20 bits
    always_comb begin
        if (i_s2.is_mod) begin
            w_sim = SIM_OTHER_BASE + 20'(w_rem_fix[16:0]);
        end else begin
            w_sim = w_sum[19:0];
        end
    end

    assign o_key = {i_s2.script, i_s2.cls, w_sim, i_s2.variant, i_s2.cp[19:0]};

endmodule
